// ----- sv/bfmr_pkg.sv -----
// shared constants and types of the brace framed motor report parser
package bfmr_pkg;

    localparam logic [7:0] START_MARK = 8'h7B;
    localparam logic [7:0] END_MARK   = 8'h7D;
    localparam logic [7:0] CHECK_SEED = 8'h55;

    localparam int unsigned NUM_PAYLOAD = 6;

    // frame position codes
    localparam logic [3:0] POS_HUNT  = 4'd0;
    localparam logic [3:0] POS_FIRST = 4'd1;
    localparam logic [3:0] POS_LAST_DATA = 4'd6;
    localparam logic [3:0] POS_CHECK = 4'd7;
    localparam logic [3:0] POS_END   = 4'd8;

    typedef logic [3:0] t_pos;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] q_voltage;
        logic signed [15:0] d_voltage;
        logic signed [15:0] wheel_speed;
    } t_frame_res;

endpackage

// ----- sv/brace_framed_motor_report_parser.sv -----
// top level of the brace framed motor report parser
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-----------------------------------------------
//  byte in  | i_valid | o_ready | i_rx_byte
//  report   | o_valid | i_ready | o_q_voltage, o_d_voltage, o_wheel_speed
//
// one byte per cycle while no report waits in the result register at the frame
// end; a byte passes the input register, then the frame tracker, and a report
// appears in the result register in the cycle after the tracker takes the closing brace
// synchronous active-low reset clears the frame position and both valid flags
// and sets the running check to its seed; payload bytes are left as they are
// a report still waiting in the result register holds the frame tracker at
// the end position, whatever the byte there; other bytes keep flowing, and
// while the tracker is held the input register keeps its byte and o_ready is low
module brace_framed_motor_report_parser import bfmr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_q_voltage,
    output logic signed [15:0] o_d_voltage,
    output logic signed [15:0] o_wheel_speed
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // tracker advance and result load
    logic       step;
    logic       can_load;
    logic       out_load;
    t_frame_res frame_res;
    t_pos       frame_pos;

    // the tracker may step unless it is at the end position while the slot is full;
    // only a closing byte at the end position can produce a report
    assign step     = r_in_valid && (can_load || frame_pos != POS_END);
    assign out_load = frame_res.hit;
    assign o_ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    bfmr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (frame_res),
        .o_pos   (frame_pos)
    );

    bfmr_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_res         (frame_res),
        .i_ready       (i_ready),
        .o_can_load    (can_load),
        .o_valid       (o_valid),
        .o_q_voltage   (o_q_voltage),
        .o_d_voltage   (o_d_voltage),
        .o_wheel_speed (o_wheel_speed)
    );

    // an empty input register always takes a byte
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input register empty but not ready");

    // frame position stays within the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_pos <= POS_END)
        else $error("frame position out of range");

    // a report is produced only at the end position into a free slot
    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (frame_pos == POS_END) && can_load)
        else $error("report produced outside frame end or into full slot");

    // after the end byte the tracker hunts again
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && frame_pos == POS_END |=> frame_pos == POS_HUNT)
        else $error("tracker did not return to hunting");

endmodule

// ----- sv/bfmr_frame.sv -----
// frame tracker: position, payload bytes, running check and frame decision
module bfmr_frame import bfmr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_frame_res o_res,
    output t_pos       o_pos
);

    t_pos       r_pos, n_pos;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_check;
    logic [7:0] r_payload [NUM_PAYLOAD];
    logic       hunting;
    logic [2:0] wr_idx;
    logic       is_data;

    assign hunting = (r_pos == POS_HUNT) || (r_pos > POS_END);
    assign is_data = !hunting && (r_pos <= POS_LAST_DATA);
    assign wr_idx  = 3'(r_pos - POS_FIRST);

    always_comb begin
        n_pos = r_pos;
        n_xor = r_xor;
        if (hunting) begin
            if (i_byte == START_MARK) begin
                n_pos = POS_FIRST;
                n_xor = CHECK_SEED;
            end else begin
                n_pos = POS_HUNT;
            end
        end else if (r_pos == POS_END) begin
            n_pos = POS_HUNT;
        end else begin
            n_pos = r_pos + 4'd1;
            if (is_data) begin
                n_xor = r_xor ^ i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_xor <= CHECK_SEED;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_xor <= n_xor;
        end
    end

    // payload and check bytes need no reset
    always_ff @(posedge i_clk) begin
        if (i_step && is_data) begin
            r_payload[wr_idx] <= i_byte;
        end
        if (i_step && r_pos == POS_CHECK) begin
            r_check <= i_byte;
        end
    end

    always_comb begin
        o_res.hit = i_step && (r_pos == POS_END) && (i_byte == END_MARK)
                    && (r_check == r_xor);
        o_res.q_voltage   = {r_payload[1], r_payload[0]};
        o_res.d_voltage   = {r_payload[3], r_payload[2]};
        o_res.wheel_speed = {r_payload[5], r_payload[4]};
    end

    assign o_pos = r_pos;

endmodule

// ----- sv/bfmr_out_reg.sv -----
// result register holding one report until it is taken
module bfmr_out_reg import bfmr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_frame_res         i_res,
    input  logic               i_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output logic signed [15:0] o_q_voltage,
    output logic signed [15:0] o_d_voltage,
    output logic signed [15:0] o_wheel_speed
);

    logic               r_valid;
    logic signed [15:0] r_q, r_d, r_s;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_res.q_voltage;
            r_d <= i_res.d_voltage;
            r_s <= i_res.wheel_speed;
        end
    end

    assign o_valid       = r_valid;
    assign o_q_voltage   = r_q;
    assign o_d_voltage   = r_d;
    assign o_wheel_speed = r_s;

endmodule

// ----- sim/tb_brace_framed_motor_report_parser.sv -----
// self-checking testbench of the brace framed motor report parser
`timescale 1ns / 1ps

module tb_brace_framed_motor_report_parser;
    import bfmr_pkg::*;

    typedef struct packed {
        logic signed [15:0] q_voltage;
        logic signed [15:0] d_voltage;
        logic signed [15:0] wheel_speed;
    } t_motor_report;

    // one queued byte, or a hold point where the sender waits for all reports
    typedef struct packed {
        logic       drain;
        logic [7:0] rx_byte;
    } t_rx_entry;

    typedef enum int {
        FLAW_NONE,
        FLAW_END,
        FLAW_CHECK,
        FLAW_SHORT
    } t_frame_flaw;

    localparam int NUM_RANDOM_BYTES = 1450;
    localparam int CALM_FROM        = 600;
    localparam int CALM_TO          = 1000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         in_byte   = 8'h00;
    logic               out_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [15:0] o_q_voltage;
    logic signed [15:0] o_d_voltage;
    logic signed [15:0] o_wheel_speed;

    t_rx_entry     byte_backlog[$];
    t_motor_report awaited_reports[$];
    int            accepted_cnt = 0;
    int            frame_byte_cnt = 0;
    int            fail_cnt = 0;

    // frame tracker mirror
    t_pos       trk_pos = POS_HUNT;
    logic [7:0] trk_payload[NUM_PAYLOAD];
    logic [7:0] trk_xor = CHECK_SEED;
    logic [7:0] trk_check = 8'h00;

    brace_framed_motor_report_parser i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (in_byte),
        .o_valid       (o_valid),
        .i_ready       (out_ready),
        .o_q_voltage   (o_q_voltage),
        .o_d_voltage   (o_d_voltage),
        .o_wheel_speed (o_wheel_speed)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic track_rx_byte(input logic [7:0] b);
        t_motor_report rep;
        if (trk_pos == POS_HUNT || trk_pos > POS_END) begin
            if (b == START_MARK) begin
                trk_pos = POS_FIRST;
                trk_xor = CHECK_SEED;
            end else begin
                trk_pos = POS_HUNT;
            end
        end else if (trk_pos <= POS_LAST_DATA) begin
            trk_payload[3'(trk_pos - POS_FIRST)] = b;
            trk_xor = trk_xor ^ b;
            trk_pos = trk_pos + 4'd1;
        end else if (trk_pos == POS_CHECK) begin
            trk_check = b;
            trk_pos = trk_pos + 4'd1;
        end else begin
            trk_pos = POS_HUNT;
            if (b == END_MARK && trk_check == trk_xor) begin
                rep.q_voltage   = {trk_payload[1], trk_payload[0]};
                rep.d_voltage   = {trk_payload[3], trk_payload[2]};
                rep.wheel_speed = {trk_payload[5], trk_payload[4]};
                awaited_reports.push_back(rep);
            end
        end
    endtask

    // random idling, except for a calm stretch in the middle of the run
    function automatic logic take_break();
        if (accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic in_frame);
        t_rx_entry ent;
        ent.drain   = 1'b0;
        ent.rx_byte = b;
        byte_backlog.push_back(ent);
        if (in_frame)
            frame_byte_cnt++;
    endtask

    task automatic push_drain();
        t_rx_entry ent;
        ent.drain   = 1'b1;
        ent.rx_byte = 8'h00;
        byte_backlog.push_back(ent);
    endtask

    task automatic push_frame(input logic [15:0] q, input logic [15:0] d,
                              input logic [15:0] s, input t_frame_flaw flaw);
        logic [7:0] body[7];
        logic [7:0] tail;
        int         keep;
        body[0] = q[7:0];
        body[1] = q[15:8];
        body[2] = d[7:0];
        body[3] = d[15:8];
        body[4] = s[7:0];
        body[5] = s[15:8];
        body[6] = CHECK_SEED ^ body[0] ^ body[1] ^ body[2] ^ body[3] ^ body[4] ^ body[5];
        tail = END_MARK;
        keep = 7;
        if (flaw == FLAW_CHECK)
            body[6] = body[6] ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_END) begin
            tail = 8'($urandom_range(255));
            if (tail == END_MARK)
                tail = ~tail;
        end
        if (flaw == FLAW_SHORT)
            keep = $urandom_range(1, 6);
        push_byte(START_MARK, 1'b1);
        for (int i = 0; i < keep; i++)
            push_byte(body[i], 1'b1);
        // a cut frame swallows whatever follows, a new brace included
        if (flaw != FLAW_SHORT)
            push_byte(tail, 1'b1);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(19))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // sender
    always @(posedge clk) begin : byte_driver
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        t_rx_entry  head;
        nxt_valid = in_valid;
        nxt_byte  = in_byte;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && o_ready) begin
                track_rx_byte(in_byte);
                accepted_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && byte_backlog.size() > 0) begin
                if (byte_backlog[0].drain) begin
                    if (awaited_reports.size() == 0)
                        head = byte_backlog.pop_front();
                end else if (!take_break()) begin
                    head      = byte_backlog.pop_front();
                    nxt_valid = 1'b1;
                    nxt_byte  = head.rx_byte;
                end
            end
        end
        in_valid <= nxt_valid;
        in_byte  <= nxt_byte;
    end

    // receiver and report check
    always @(posedge clk) begin : report_monitor
        t_motor_report want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected report q=%0d d=%0d speed=%0d", $time,
                             o_q_voltage, o_d_voltage, o_wheel_speed);
                    fail_cnt++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (o_q_voltage !== want.q_voltage) begin
                        $display("%0t: q_voltage expected %0d got %0d", $time,
                                 want.q_voltage, o_q_voltage);
                        fail_cnt++;
                    end
                    if (o_d_voltage !== want.d_voltage) begin
                        $display("%0t: d_voltage expected %0d got %0d", $time,
                                 want.d_voltage, o_d_voltage);
                        fail_cnt++;
                    end
                    if (o_wheel_speed !== want.wheel_speed) begin
                        $display("%0t: wheel_speed expected %0d got %0d", $time,
                                 want.wheel_speed, o_wheel_speed);
                        fail_cnt++;
                    end
                end
            end
            out_ready <= !take_break();
        end
    end

    initial begin : run_ctrl
        int          waited;
        int          pick;
        t_frame_flaw flaw;
        logic [7:0]  noise;

        // directed: ignored noise, field extremes, braces as data, bad check, bad end mark
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_frame(16'h8000, 16'h7FFF, 16'hFFFF, FLAW_NONE);
        push_frame({START_MARK, END_MARK}, 16'h0000, {8'h00, START_MARK}, FLAW_NONE);
        push_frame(16'h1234, 16'h5678, 16'h9ABC, FLAW_CHECK);
        push_frame(16'h0001, 16'hFFFE, 16'h00FF, FLAW_END);
        push_drain();

        // random: mostly good frames, some broken ones, some line noise, rare hold points
        while (frame_byte_cnt < NUM_RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 80)
                flaw = FLAW_NONE;
            else if (pick < 88)
                flaw = FLAW_END;
            else if (pick < 95)
                flaw = FLAW_CHECK;
            else
                flaw = FLAW_SHORT;
            push_frame(rand_field(), rand_field(), rand_field(), flaw);
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 3)) begin
                    noise = 8'($urandom_range(255));
                    if (noise == START_MARK && $urandom_range(19) != 0)
                        noise = 8'h00;
                    push_byte(noise, 1'b0);
                end
            end
            if ($urandom_range(199) == 0)
                push_drain();
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (awaited_reports.size() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (awaited_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, awaited_reports.size());
            fail_cnt += awaited_reports.size();
        end
        if (fail_cnt == 0)
            $display("tb_brace_framed_motor_report_parser passed");
        else
            $display("tb_brace_framed_motor_report_parser failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_brace_framed_motor_report_parser failed");
        $finish;
    end

endmodule
